// ===== src/sdi_pkg.sv =====
// sdi_pkg: shared types and constants of the sun direction pipeline
// almanac rates and bases as q64 turns, cordic arctangent table and stage type
// no dependencies
package sdi_pkg;

    localparam int unsigned IN_W  = 42;
    localparam int unsigned IN_TW = 48;
    localparam int unsigned CW    = 32;
    localparam int unsigned ZW    = 33;

    localparam logic [21:0] EPOCH_DAY = 22'd2451545;
    localparam logic signed [CW-1:0] GAIN_Q30 = 32'sh26DD3B6A;
    localparam logic signed [CW-1:0] QUARTER  = 32'sh40000000;
    localparam logic signed [ZW-1:0] HALF     = 33'sh080000000;

    localparam int unsigned ANG_L = 0;
    localparam int unsigned ANG_G = 1;
    localparam int unsigned ANG_E = 2;

    function automatic logic [63:0] ratio_q64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = '0;
        for (int i = 0; i < 64; i++) begin
            rem = {rem[62:0], 1'b0};
            q   = {q[62:0], 1'b0};
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam logic [63:0] RATE [3] = '{
        ratio_q64(64'd9856474, 64'd3600000000),
        ratio_q64(64'd9856003, 64'd3600000000),
        ratio_q64(64'd4, 64'd3600000000)
    };
    localparam logic [63:0] BASE [3] = '{
        ratio_q64(64'd280460, 64'd360000),
        ratio_q64(64'd357528, 64'd360000),
        ratio_q64(64'd23439, 64'd360000)
    };

    localparam logic [63:0] AMP1_Q64 = ratio_q64(64'd1915, 64'd360000);
    localparam logic [63:0] AMP2_Q64 = ratio_q64(64'd20, 64'd360000);
    localparam logic [31:0] AMP1 = AMP1_Q64[63:32];
    localparam logic [31:0] AMP2 = AMP2_Q64[63:32];

    localparam logic [31:0] ATAN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_crd;

endpackage

// ===== src/sun_direction_inertial.sv =====
// sun_direction_inertial: sun unit vector in the inertial frame from one julian date
// takes one beat per cycle while no result waits unaccepted at the output
// the two cordic passes (fold register plus one cell per stage) set the depth
// one pipeline enable: the whole pipe holds while a result waits at the output
// synchronous active-low reset clears the valid line only, no payload reset
// depends on sdi_pkg, sdi_almanac, sdi_cordic
module sun_direction_inertial #(
    parameter int unsigned DATE_FRAC_BITS = 20,
    parameter int unsigned OUT_FRAC_BITS  = 16,
    parameter int unsigned CORDIC_STAGES  = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [sdi_pkg::IN_TW-1:0] i_s_axis_tdata,  // julian_date
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata  // dir_x, dir_y, dir_z
);

    localparam int unsigned OW  = OUT_FRAC_BITS + 2;
    localparam int unsigned OTW = ((3*OW+7)/8)*8;
    localparam int unsigned CA  = CORDIC_STAGES + 1;
    localparam int unsigned LAT = 7 + 2*CA;
    localparam int unsigned S1  = 30 - OUT_FRAC_BITS;
    localparam int unsigned S2  = 60 - OUT_FRAC_BITS;
    localparam logic signed [64:0] RND1 = (S1 > 0) ? (65'sd1 <<< (S1-1)) : 65'sd0;
    localparam logic signed [64:0] RND2 = 65'sd1 <<< (S2-1);
    localparam logic signed [64:0] RNDC = 65'sd1 <<< 29;
    localparam logic signed [64:0] LIM  = 65'sd1 <<< OUT_FRAC_BITS;

    logic                       w_en;
    logic [LAT-1:0]             r_vld;
    logic [sdi_pkg::IN_W-1:0]   r_jd;
    logic [31:0]                w_lon;
    logic [31:0]                w_anom;
    logic [31:0]                w_obl;
    logic signed [31:0]         w_s1;
    logic signed [31:0]         w_s2;
    logic [63:0]                r_dly [CA];
    logic signed [64:0]         r_pc1;
    logic signed [64:0]         r_pc2;
    logic [31:0]                r_lon3;
    logic [31:0]                r_obl3;
    logic signed [64:0]         w_rs1;
    logic signed [64:0]         w_rs2;
    logic [31:0]                r_lam;
    logic [31:0]                r_obl4;
    logic signed [31:0]         w_cl;
    logic signed [31:0]         w_sl;
    logic signed [31:0]         w_ce;
    logic signed [31:0]         w_se;
    logic signed [31:0]         r_cl;
    logic signed [63:0]         r_py;
    logic signed [63:0]         r_pz;
    logic signed [64:0]         w_vx;
    logic signed [64:0]         w_vy;
    logic signed [64:0]         w_vz;
    logic [OW-1:0]              r_dx;
    logic [OW-1:0]              r_dy;
    logic [OW-1:0]              r_dz;

    function automatic logic [OW-1:0] sat(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v;
        if (v > LIM) begin
            t = LIM;
        end else if (v < -LIM) begin
            t = -LIM;
        end
        return t[OW-1:0];
    endfunction

    assign w_en            = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_jd <= i_s_axis_tdata[sdi_pkg::IN_W-1:0];
        end
    end

    sdi_almanac #(.DATE_FRAC_BITS(DATE_FRAC_BITS)) u_almanac (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_jd   (r_jd),
        .o_lon  (w_lon),
        .o_anom (w_anom),
        .o_obl  (w_obl)
    );

    sdi_cordic #(.STAGES(CORDIC_STAGES)) u_crd_g1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (w_anom),
        .o_cos   (),
        .o_sin   (w_s1)
    );

    sdi_cordic #(.STAGES(CORDIC_STAGES)) u_crd_g2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle ({w_anom[30:0], 1'b0}),
        .o_cos   (),
        .o_sin   (w_s2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= {w_lon, w_obl};
            for (int k = 1; k < CA; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc1  <= $signed({1'b0, sdi_pkg::AMP1}) * w_s1;
            r_pc2  <= $signed({1'b0, sdi_pkg::AMP2}) * w_s2;
            r_lon3 <= r_dly[CA-1][63:32];
            r_obl3 <= r_dly[CA-1][31:0];
        end
    end

    assign w_rs1 = (r_pc1 + RNDC) >>> 30;
    assign w_rs2 = (r_pc2 + RNDC) >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lam  <= r_lon3 + w_rs1[31:0] + w_rs2[31:0];
            r_obl4 <= r_obl3;
        end
    end

    sdi_cordic #(.STAGES(CORDIC_STAGES)) u_crd_lam (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_lam),
        .o_cos   (w_cl),
        .o_sin   (w_sl)
    );

    sdi_cordic #(.STAGES(CORDIC_STAGES)) u_crd_obl (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_obl4),
        .o_cos   (w_ce),
        .o_sin   (w_se)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cl <= w_cl;
            r_py <= w_ce * w_sl;
            r_pz <= w_se * w_sl;
        end
    end

    assign w_vx = (65'(r_cl) + RND1) >>> S1;
    assign w_vy = (65'(r_py) + RND2) >>> S2;
    assign w_vz = (65'(r_pz) + RND2) >>> S2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= sat(w_vx);
            r_dy <= sat(w_vy);
            r_dz <= sat(w_vz);
        end
    end

    assign o_m_axis_tdata = OTW'({r_dz, r_dy, r_dx});

endmodule

// ===== src/sdi_cordic_cell.sv =====
// sdi_cordic_cell: one registered rotation step of the cordic chain
// depends on sdi_pkg
module sdi_cordic_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  sdi_pkg::t_crd i_st,
    output sdi_pkg::t_crd o_st
);

    sdi_pkg::t_crd r_st;
    sdi_pkg::t_crd n_st;
    logic signed [sdi_pkg::CW-1:0] w_dx;
    logic signed [sdi_pkg::CW-1:0] w_dy;
    logic signed [sdi_pkg::ZW-1:0] w_a;

    always_comb begin
        w_dx = i_st.y >>> IDX;
        w_dy = i_st.x >>> IDX;
        w_a  = $signed({1'b0, sdi_pkg::ATAN[IDX]});
        n_st = i_st;
        if (!i_st.z[sdi_pkg::ZW-1]) begin
            n_st.x = i_st.x - w_dx;
            n_st.y = i_st.y + w_dy;
            n_st.z = i_st.z - w_a;
        end else begin
            n_st.x = i_st.x + w_dx;
            n_st.y = i_st.y - w_dy;
            n_st.z = i_st.z + w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== src/sdi_cordic.sv =====
// sdi_cordic: pipelined rotation cordic, quadrant fold register then a row of cells
// depends on sdi_pkg and sdi_cordic_cell
module sdi_cordic #(
    parameter int unsigned STAGES = 18
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [31:0]                   i_angle,
    output logic signed [sdi_pkg::CW-1:0] o_cos,
    output logic signed [sdi_pkg::CW-1:0] o_sin
);

    sdi_pkg::t_crd r_fold;
    sdi_pkg::t_crd n_fold;
    sdi_pkg::t_crd w_st [STAGES+1];
    logic signed [31:0] w_a;
    logic signed [sdi_pkg::ZW-1:0] w_z;

    always_comb begin
        w_a = $signed(i_angle);
        w_z = {w_a[31], w_a};
        n_fold.x    = sdi_pkg::GAIN_Q30;
        n_fold.y    = '0;
        n_fold.z    = w_z;
        n_fold.flip = 1'b0;
        if (!w_a[31] && w_a > sdi_pkg::QUARTER) begin
            n_fold.z    = w_z - sdi_pkg::HALF;
            n_fold.flip = 1'b1;
        end else if (w_a[31] && w_a < -sdi_pkg::QUARTER) begin
            n_fold.z    = w_z + sdi_pkg::HALF;
            n_fold.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold <= n_fold;
        end
    end

    assign w_st[0] = r_fold;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        sdi_cordic_cell #(.IDX(i)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_st  (w_st[i]),
            .o_st  (w_st[i+1])
        );
    end

    assign o_cos = w_st[STAGES].flip ? -w_st[STAGES].x : w_st[STAGES].x;
    assign o_sin = w_st[STAGES].flip ? -w_st[STAGES].y : w_st[STAGES].y;

endmodule

// ===== src/sdi_almanac.sv =====
// sdi_almanac: days since epoch times the almanac rates, two register stages
// gives mean longitude, mean anomaly and obliquity as 32-bit binary angles; depends on sdi_pkg
module sdi_almanac #(
    parameter int unsigned DATE_FRAC_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [sdi_pkg::IN_W-1:0] i_jd,
    output logic [31:0]              o_lon,
    output logic [31:0]              o_anom,
    output logic [31:0]              o_obl
);

    localparam int unsigned DW = sdi_pkg::IN_W - DATE_FRAC_BITS;
    localparam int unsigned WW = ((DW > 22) ? DW : 22) + 1;
    localparam int unsigned LW = WW + 33;
    localparam int unsigned FW = DATE_FRAC_BITS + 32;
    localparam int unsigned FS = 24 - DATE_FRAC_BITS;

    logic signed [WW-1:0] w_whole;
    logic [63:0]          w_whole64;
    logic [63:0]          w_hi_full [3];

    logic signed [LW-1:0] r_lo [3];
    logic [31:0]          r_hi [3];
    logic [FW-1:0]        r_fr [3];
    logic [63:0]          w_part [3];
    logic [63:0]          w_ang [3];
    logic [31:0]          r_lon;
    logic [31:0]          r_anom;
    logic [31:0]          r_obl;

    always_comb begin
        w_whole   = $signed(WW'(i_jd[sdi_pkg::IN_W-1:DATE_FRAC_BITS]))
                  - $signed(WW'(sdi_pkg::EPOCH_DAY));
        w_whole64 = 64'(w_whole);
        for (int k = 0; k < 3; k++) begin
            w_hi_full[k] = w_whole64[31:0] * sdi_pkg::RATE[k][63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= w_whole * $signed({1'b0, sdi_pkg::RATE[k][31:0]});
                r_hi[k] <= w_hi_full[k][31:0];
                r_fr[k] <= i_jd[DATE_FRAC_BITS-1:0] * sdi_pkg::RATE[k][55:24];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_part[k] = 64'(r_lo[k]) + {r_hi[k], 32'd0} + (64'(r_fr[k]) << FS);
        end
        w_ang[sdi_pkg::ANG_L] = sdi_pkg::BASE[sdi_pkg::ANG_L] + w_part[sdi_pkg::ANG_L];
        w_ang[sdi_pkg::ANG_G] = sdi_pkg::BASE[sdi_pkg::ANG_G] + w_part[sdi_pkg::ANG_G];
        w_ang[sdi_pkg::ANG_E] = sdi_pkg::BASE[sdi_pkg::ANG_E] - w_part[sdi_pkg::ANG_E];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lon  <= w_ang[sdi_pkg::ANG_L][63:32];
            r_anom <= w_ang[sdi_pkg::ANG_G][63:32];
            r_obl  <= w_ang[sdi_pkg::ANG_E][63:32];
        end
    end

    assign o_lon  = r_lon;
    assign o_anom = r_anom;
    assign o_obl  = r_obl;

endmodule
